// File: hw/rtl/assert_macros.svh
// assertion macros shared by the slot allocator rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define GSA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// implication checked at every clock edge outside reset
`define GSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GSA_ASSERT(label, clk, rst, prop)
`define GSA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/gsa_pkg.sv
// shared constants, codes and control structs of the slot allocator
// no dependencies
`default_nettype none
package gsa_pkg;

   // table geometry, fixed by the 8-bit slot field of a handle
   localparam int SLOTS   = 256;
   localparam int SLOT_W  = 8;
   localparam int CHECK_W = 8;
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(SLOTS);

   // check counter value after reset
   localparam logic [CHECK_W-1:0] RESET_CHECK = 8'd124;

   // command codes
   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_FREE     = 2'd1;
   localparam logic [1:0] CMD_VALIDATE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request beat, start memory reads
      logic commit;   // apply update, load result register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free; // result register can take a new beat this cycle
   } dp_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/gsa_controller.sv
// two-state sequencer of the slot allocator: accept, then commit
// depends on gsa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module gsa_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire gsa_pkg::dp_stat_type stat,
   output gsa_pkg::ctl_cmd_type     ctl
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // command decode
   assign ctl.load   = req_valid && ready_ff;
   assign ctl.commit = (state_ff == S_EXEC) && stat.out_free;
   assign req_ready  = ready_ff;

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   // checks
   `GSA_ASSERT(a_no_load_and_commit, clock, reset, !(ctl.load && ctl.commit))
   `GSA_ASSERT_NEXT(a_load_enters_exec, clock, reset, ctl.load, state_ff == S_EXEC)
   `GSA_ASSERT_IMPL(a_ready_only_idle, clock, reset, ready_ff, state_ff == S_IDLE)

endmodule
`default_nettype wire

// File: hw/rtl/gsa_datapath.sv
// check store, free stack, counters and result register of the slot allocator
// depends on gsa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module gsa_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire gsa_pkg::ctl_cmd_type                ctl,
   output gsa_pkg::dp_stat_type                     stat,
   input  wire logic [1:0]                          req_command,
   input  wire logic [gsa_pkg::SLOT_W-1:0]          req_handle_slot,
   input  wire logic [gsa_pkg::CHECK_W-1:0]         req_handle_check,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [gsa_pkg::SLOT_W-1:0]               rsp_slot_index,
   output logic [gsa_pkg::CHECK_W-1:0]              rsp_slot_check
);

   // memories; unwritten entries and slot 0 may be read but never decide a result
   logic [gsa_pkg::CHECK_W-1:0] check_mem [gsa_pkg::SLOTS];
   logic [gsa_pkg::SLOT_W-1:0]  free_mem  [gsa_pkg::SLOTS];

   // captured request and read data
   logic [1:0]                  command_ff;
   logic [gsa_pkg::SLOT_W-1:0]  slot_ff;
   logic [gsa_pkg::CHECK_W-1:0] check_ff;
   logic [gsa_pkg::CHECK_W-1:0] rd_check_ff;
   logic [gsa_pkg::SLOT_W-1:0]  rd_free_ff;

   // counters
   logic [gsa_pkg::COUNT_W-1:0] free_count_ff, free_count_in;
   logic [gsa_pkg::COUNT_W-1:0] used_count_ff, used_count_in;
   logic [gsa_pkg::CHECK_W-1:0] check_counter_ff, check_counter_in;

   // result register
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff, res_status;
   logic [gsa_pkg::SLOT_W-1:0]  rsp_index_ff, res_index;
   logic [gsa_pkg::CHECK_W-1:0] rsp_check_ff, res_check;

   // write ports
   logic                        ck_we;
   logic [gsa_pkg::SLOT_W-1:0]  ck_waddr;
   logic [gsa_pkg::CHECK_W-1:0] ck_wdata;
   logic                        fs_we;

   logic [gsa_pkg::SLOT_W-1:0]  free_top;
   logic [gsa_pkg::SLOT_W-1:0]  alloc_idx;
   logic [gsa_pkg::CHECK_W-1:0] next_check;
   logic                        has_free, has_room, stack_room, handle_ok, alloc_ok;
   logic                        alloc_commit;

   assign free_top = free_count_ff[gsa_pkg::SLOT_W-1:0] - gsa_pkg::SLOT_W'(1);

   // capture request beat and read both memories
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         command_ff  <= req_command;
         slot_ff     <= req_handle_slot;
         check_ff    <= req_handle_check;
         rd_check_ff <= check_mem[req_handle_slot];
         rd_free_ff  <= free_mem[free_top];
      end
   end

   // handle validation and allocation source
   assign has_free   = (free_count_ff != '0);
   assign has_room   = (used_count_ff < gsa_pkg::SLOT_LIMIT);
   assign stack_room = (free_count_ff < gsa_pkg::SLOT_LIMIT);
   assign handle_ok  = (slot_ff != '0) && ({1'b0, slot_ff} < used_count_ff)
                       && (rd_check_ff == check_ff);
   assign next_check = check_counter_ff + gsa_pkg::CHECK_W'(1);

   // command execution
   always_comb begin
      free_count_in    = free_count_ff;
      used_count_in    = used_count_ff;
      check_counter_in = check_counter_ff;
      ck_we            = 1'b0;
      ck_waddr         = slot_ff;
      ck_wdata         = rd_check_ff + gsa_pkg::CHECK_W'(1);
      fs_we            = 1'b0;
      alloc_ok         = 1'b0;
      alloc_idx        = rd_free_ff;
      res_status       = gsa_pkg::ST_BAD;
      res_index        = '0;
      res_check        = '0;
      unique case (command_ff)
         gsa_pkg::CMD_ALLOC: begin
            if (has_free) begin
               alloc_ok      = 1'b1;
               alloc_idx     = rd_free_ff;
               free_count_in = free_count_ff - gsa_pkg::COUNT_W'(1);
            end else if (has_room) begin
               alloc_ok      = 1'b1;
               alloc_idx     = used_count_ff[gsa_pkg::SLOT_W-1:0];
               used_count_in = used_count_ff + gsa_pkg::COUNT_W'(1);
            end
            if (alloc_ok) begin
               check_counter_in = next_check;
               ck_we            = 1'b1;
               ck_waddr         = alloc_idx;
               ck_wdata         = next_check;
               res_status       = gsa_pkg::ST_OK;
               res_index        = alloc_idx;
               res_check        = next_check;
            end else begin
               res_status = gsa_pkg::ST_FULL;
            end
         end
         gsa_pkg::CMD_FREE: begin
            if (handle_ok && stack_room) begin
               ck_we         = 1'b1;
               fs_we         = 1'b1;
               free_count_in = free_count_ff + gsa_pkg::COUNT_W'(1);
               res_status    = gsa_pkg::ST_OK;
            end
         end
         gsa_pkg::CMD_VALIDATE: begin
            if (handle_ok) begin
               res_status = gsa_pkg::ST_OK;
               res_index  = slot_ff;
            end
         end
         default: begin
            res_status = gsa_pkg::ST_BAD;
         end
      endcase
   end

   // memory writes on commit
   always_ff @(posedge clock) begin
      if (ctl.commit && ck_we) begin
         check_mem[ck_waddr] <= ck_wdata;
      end
      if (ctl.commit && fs_we) begin
         free_mem[free_count_ff[gsa_pkg::SLOT_W-1:0]] <= slot_ff;
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff    <= '0;
         used_count_ff    <= gsa_pkg::COUNT_W'(1);
         check_counter_ff <= gsa_pkg::RESET_CHECK;
      end else if (ctl.commit) begin
         free_count_ff    <= free_count_in;
         used_count_ff    <= used_count_in;
         check_counter_ff <= check_counter_in;
      end
   end

   // result register, holds the beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_check_ff  <= res_check;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_index_ff;
   assign rsp_slot_check = rsp_check_ff;

   // successful allocation being applied this cycle
   assign alloc_commit = ctl.commit && alloc_ok;

   // checks
   `GSA_ASSERT(a_free_count_range, clock, reset, free_count_ff <= gsa_pkg::SLOT_LIMIT)
   `GSA_ASSERT(a_used_count_nonzero, clock, reset, used_count_ff != '0)
   `GSA_ASSERT(a_used_count_range, clock, reset, used_count_ff <= gsa_pkg::SLOT_LIMIT)
   `GSA_ASSERT_NEXT(a_alloc_bump, clock, reset, alloc_commit, check_counter_ff == $past(next_check))

endmodule
`default_nettype wire

// File: hw/rtl/generational_slot_allocator_top.sv
// Slot allocator: handles of slot index plus check byte, free stack reuse.
// A request beat is accepted in S_IDLE; its result is registered on commit in
// S_EXEC, which waits while a stalled result still holds the result register.
// One request at a time: the check store and free stack are read, then written.
// Reset clears counters and handshake state; the stores are not cleared.
// depends on gsa_pkg, gsa_controller, gsa_datapath
`default_nettype none
module generational_slot_allocator_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_command,
   input  wire logic [gsa_pkg::SLOT_W-1:0]  req_handle_slot,
   input  wire logic [gsa_pkg::CHECK_W-1:0] req_handle_check,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [gsa_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [gsa_pkg::CHECK_W-1:0]      rsp_slot_check
);

   gsa_pkg::ctl_cmd_type ctl;
   gsa_pkg::dp_stat_type stat;

   // sequencer
   gsa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // storage and result path
   gsa_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_handle_slot  (req_handle_slot),
      .req_handle_check (req_handle_check),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_slot_check   (rsp_slot_check)
   );

endmodule
`default_nettype wire
